// File: rtl/core/urs_pkg.sv
`timescale 1ns / 1ps

package urs_pkg;

   // counter and field widths
   localparam int TIMER_W    = 32;
   localparam int DIST_W     = 16;
   localparam int TICK_NS_W  = 10;
   localparam int SHORT_W    = 16;
   localparam int NS_W       = TIMER_W + TICK_NS_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
   localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

   // distance = ns * 340 / 200000 = ns * 17 / 10000, done as a reciprocal multiply
   // widths below which the distance stays under the saturation point
   localparam int                    NS_OPER_W   = 26;
   localparam logic [NS_W-1:0]       NS_SAT_LIMIT = NS_W'(38550589);
   localparam int                    RECIP_SHIFT = 40;
   localparam int                    RECIP_W     = 31;
   localparam logic [RECIP_W-1:0]    RECIP_MULT  = RECIP_W'(1869169768);
   localparam int                    PROD_W      = NS_OPER_W + RECIP_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_NS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_LOW      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TIMEOUT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD       = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_ECHO   = 2'd1;
   localparam logic [1:0] ST_TRUNCATED = 2'd2;

   typedef enum logic [2:0] {
      PH_PRE_LOW   = 3'd0,
      PH_TRIGGER   = 3'd1,
      PH_WAIT_RISE = 3'd2,
      PH_MEASURE   = 3'd3,
      PH_IDLE      = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      DIST_HOLD  = 2'd0,
      DIST_LOAD  = 2'd1,
      DIST_CLEAR = 2'd2
   } dist_op_type;

   // per-tick result flags carried down the distance pipeline
   typedef struct packed {
      logic        drive_en;
      logic        drive_lvl;
      logic        res_valid;
      logic [1:0]  status;
      dist_op_type op;
   } tick_flags_type;

endpackage

// File: rtl/core/urs_req_if.sv
`timescale 1ns / 1ps

interface urs_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink   (input valid, input echo_level, output ready);
endinterface

// File: rtl/core/urs_rsp_if.sv
`timescale 1ns / 1ps

interface urs_rsp_if;
   logic        valid;
   logic        ready;
   logic        pin_drive_enable;
   logic        pin_drive_level;
   logic        result_valid;
   logic [15:0] distance_tenth_mm;
   logic [1:0]  status;

   modport source (output valid, output pin_drive_enable, output pin_drive_level,
                   output result_valid, output distance_tenth_mm, output status,
                   input ready);
   modport sink   (input valid, input pin_drive_enable, input pin_drive_level,
                   input result_valid, input distance_tenth_mm, input status,
                   output ready);
endinterface

// File: rtl/core/ultrasonic_range_sequencer.sv
`timescale 1ns / 1ps
// throughput: one tick per cycle; the whole four-stage pipe (sequencer, ns multiply,
//    reciprocal multiply, output register) advances together whenever the output is free
// reset: synchronous; sequencer restarts in the pre-low phase, counters and held
//    distance go to zero, registers return to their defaults, pipe empties

module ultrasonic_range_sequencer
   import urs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   urs_req_if.sink               req,
   urs_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [TICK_NS_W-1:0] tick_ns_ff;
   logic [SHORT_W-1:0]   pre_low_ff;
   logic [SHORT_W-1:0]   trigger_ff;
   logic [TIMER_W-1:0]   rise_timeout_ff;
   logic [TIMER_W-1:0]   echo_timeout_ff;
   logic [TIMER_W-1:0]   period_ff;

   // sequencer state
   phase_type            phase_ff, phase_in;
   logic [TIMER_W-1:0]   phase_ticks_ff, phase_ticks_in;
   logic [TIMER_W-1:0]   period_count_ff, period_count_in;

   // pipeline
   logic                 advance;
   logic                 accept;
   tick_flags_type       s1_flags_ff, s1_flags_in;
   logic [TIMER_W-1:0]   s1_ticks_ff, s1_ticks_in;
   logic                 s1_valid_ff;
   tick_flags_type       s2_flags_ff;
   logic [NS_W-1:0]      s2_ns_ff;
   logic                 s2_valid_ff;
   tick_flags_type       s3_flags_ff;
   logic [PROD_W-1:0]    s3_prod_ff;
   logic                 s3_sat_ff;
   logic                 s3_valid_ff;
   logic                 out_valid_ff;
   logic                 out_en_ff;
   logic                 out_lvl_ff;
   logic                 out_res_ff;
   logic [1:0]           out_status_ff;
   logic [DIST_W-1:0]    last_dist_ff, last_dist_in;

   // whole pipe moves when the output register is empty or being drained
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;
   assign accept    = req.valid && advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ns_ff      <= TICK_NS_W'(10);
         pre_low_ff      <= SHORT_W'(200);
         trigger_ff      <= SHORT_W'(1000);
         rise_timeout_ff <= TIMER_W'(500000000);
         echo_timeout_ff <= TIMER_W'(10000000);
         period_ff       <= TIMER_W'(50000000);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TICK_NS:      tick_ns_ff      <= csr_wdata[TICK_NS_W-1:0];
            CSR_PRE_LOW:      pre_low_ff      <= csr_wdata[SHORT_W-1:0];
            CSR_TRIGGER:      trigger_ff      <= csr_wdata[SHORT_W-1:0];
            CSR_RISE_TIMEOUT: rise_timeout_ff <= csr_wdata[TIMER_W-1:0];
            CSR_ECHO_TIMEOUT: echo_timeout_ff <= csr_wdata[TIMER_W-1:0];
            CSR_PERIOD:       period_ff       <= csr_wdata[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PRE_LOW;
         phase_ticks_ff  <= '0;
         period_count_ff <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         phase_ticks_ff  <= phase_ticks_in;
         period_count_ff <= period_count_in;
      end
   end

   // sequencer next state and per-tick flags
   always_comb begin
      logic [TIMER_W-1:0] ticks_inc;
      logic [TIMER_W-1:0] period_inc;
      ticks_inc  = (phase_ticks_ff == TIMER_MAX) ? TIMER_MAX : phase_ticks_ff + 1'b1;
      period_inc = (period_count_ff == TIMER_MAX) ? TIMER_MAX : period_count_ff + 1'b1;

      phase_in       = phase_ff;
      phase_ticks_in = phase_ticks_ff;
      s1_ticks_in    = phase_ticks_ff;
      s1_flags_in    = '{drive_en: 1'b0, drive_lvl: 1'b0, res_valid: 1'b0,
                         status: ST_OK, op: DIST_HOLD};

      unique case (phase_ff)
         PH_PRE_LOW: begin
            s1_flags_in.drive_en = 1'b1;
            phase_ticks_in       = ticks_inc;
            if (ticks_inc >= TIMER_W'(pre_low_ff)) begin
               phase_in       = PH_TRIGGER;
               phase_ticks_in = '0;
            end
         end
         PH_TRIGGER: begin
            s1_flags_in.drive_en  = 1'b1;
            s1_flags_in.drive_lvl = 1'b1;
            phase_ticks_in        = ticks_inc;
            if (ticks_inc >= TIMER_W'(trigger_ff)) begin
               phase_in       = PH_WAIT_RISE;
               phase_ticks_in = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (req.echo_level) begin
               phase_ticks_in = TIMER_W'(1);
               s1_ticks_in    = TIMER_W'(1);
               if (echo_timeout_ff <= TIMER_W'(1)) begin
                  s1_flags_in.res_valid = 1'b1;
                  s1_flags_in.status    = ST_TRUNCATED;
                  s1_flags_in.op        = DIST_LOAD;
                  phase_in              = PH_IDLE;
               end else begin
                  phase_in = PH_MEASURE;
               end
            end else begin
               phase_ticks_in = ticks_inc;
               if (ticks_inc >= rise_timeout_ff) begin
                  s1_flags_in.res_valid = 1'b1;
                  s1_flags_in.status    = ST_NO_ECHO;
                  s1_flags_in.op        = DIST_CLEAR;
                  phase_in              = PH_IDLE;
               end
            end
         end
         PH_MEASURE: begin
            if (!req.echo_level) begin
               s1_flags_in.res_valid = 1'b1;
               s1_flags_in.status    = ST_OK;
               s1_flags_in.op        = DIST_LOAD;
               phase_in              = PH_IDLE;
            end else begin
               phase_ticks_in = ticks_inc;
               s1_ticks_in    = ticks_inc;
               if (ticks_inc >= echo_timeout_ff) begin
                  s1_flags_in.res_valid = 1'b1;
                  s1_flags_in.status    = ST_TRUNCATED;
                  s1_flags_in.op        = DIST_LOAD;
                  phase_in              = PH_IDLE;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // period restart
      period_count_in = period_inc;
      if (phase_in == PH_IDLE && period_inc >= period_ff) begin
         phase_in        = PH_PRE_LOW;
         phase_ticks_in  = '0;
         period_count_in = '0;
      end
   end

   // held distance update at the output stage
   always_comb begin
      case (s3_flags_ff.op)
         DIST_LOAD:  last_dist_in = s3_sat_ff ? DIST_MAX
                                              : s3_prod_ff[RECIP_SHIFT +: DIST_W];
         DIST_CLEAR: last_dist_in = '0;
         default:    last_dist_in = last_dist_ff;
      endcase
   end

   // pipeline valid bits and held distance
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_dist_ff <= '0;
      end else if (advance) begin
         s1_valid_ff  <= req.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
         if (s3_valid_ff) begin
            last_dist_ff <= last_dist_in;
         end
      end
   end

   // pipeline payload: ns multiply, then reciprocal multiply for the divide
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flags_ff   <= s1_flags_in;
         s1_ticks_ff   <= s1_ticks_in;
         s2_flags_ff   <= s1_flags_ff;
         s2_ns_ff      <= NS_W'(s1_ticks_ff) * NS_W'(tick_ns_ff);
         s3_flags_ff   <= s2_flags_ff;
         s3_sat_ff     <= (s2_ns_ff >= NS_SAT_LIMIT);
         s3_prod_ff    <= PROD_W'(s2_ns_ff[NS_OPER_W-1:0]) * PROD_W'(RECIP_MULT);
         out_en_ff     <= s3_flags_ff.drive_en;
         out_lvl_ff    <= s3_flags_ff.drive_lvl;
         out_res_ff    <= s3_flags_ff.res_valid;
         out_status_ff <= s3_flags_ff.status;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.pin_drive_enable  = out_en_ff;
   assign rsp.pin_drive_level   = out_lvl_ff;
   assign rsp.result_valid      = out_res_ff;
   assign rsp.status            = out_status_ff;
   assign rsp.distance_tenth_mm = last_dist_ff;

   // a no-echo result always clears the held distance
   a_no_echo_clears: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_flags_ff.status == ST_NO_ECHO |-> s1_flags_ff.op == DIST_CLEAR)
      else $error("no-echo result without distance clear");

   // below the saturation point the quotient fits the distance field
   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s3_sat_ff |-> s3_prod_ff[PROD_W-1:RECIP_SHIFT+DIST_W] == '0)
      else $error("distance quotient overflows");

   // status is nonzero only when a result is reported
   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_res_ff |-> out_status_ff == ST_OK)
      else $error("status set without a result");

   // the pin is driven high only while it is driven
   a_drive_level: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_lvl_ff |-> out_en_ff)
      else $error("drive level without drive enable");

endmodule
